// ===== design/lfp_pkg.sv =====
package lfp_pkg;

  // configuration register map
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_COSH = 3'd0,
    REG_SOVT = 3'd1,
    REG_TCS  = 3'd2,
    REG_EVG  = 3'd3,
    REG_PW   = 3'd4,
    REG_VW   = 3'd5
  } reg_idx_t;

  // coefficient values after reset, coefficient format
  localparam logic [31:0] COSH_RST = 32'd151902591;
  localparam logic [31:0] SOVT_RST = 32'd546012817;
  localparam logic [31:0] TCS_RST  = 32'd41744230;
  localparam logic [31:0] EVG_RST  = 32'd67793374;
  localparam logic [31:0] PW_RST   = 32'd791196;
  localparam logic [31:0] VW_RST   = 32'd319706;

  // stream payload widths
  localparam int IN_DW   = 64;
  localparam int OUT_DW  = 112;
  localparam int CNT_W   = 16;
  localparam int FIELD_W = 32;

  // operand sources of the datapath
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_NF,
    SRC_XI,
    SRC_VI,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_T4,
    SRC_T5,
    SRC_MUL
  } src_t;

  // write-back targets of the alu
  typedef enum logic [2:0] {
    DST_NONE,
    DST_NF,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3,
    DST_T4,
    DST_T5
  } dst_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_HALF
  } alu_op_t;

  // coefficient fed to the multiplier
  typedef enum logic [2:0] {
    K_COSH,
    K_SOVT,
    K_TCS,
    K_EVG,
    K_PW,
    K_VW,
    K_OMC
  } coef_sel_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // one microcode word
  typedef struct packed {
    src_t      alu_a;
    src_t      alu_b;
    alu_op_t   op;
    dst_t      dst;
    logic      mul_en;
    src_t      mul_a;
    coef_sel_t mul_k;
    logic      fin;
  } ctrl_t;

  localparam int PC_W     = 5;
  localparam int PROG_LEN = 20;

  function automatic ctrl_t ucw(input src_t a, input src_t b, input alu_op_t op,
                                input dst_t wd, input logic men, input src_t ma,
                                input coef_sel_t mk, input logic last);
    ctrl_t w;
    w.alu_a  = a;
    w.alu_b  = b;
    w.op     = op;
    w.dst    = wd;
    w.mul_en = men;
    w.mul_a  = ma;
    w.mul_k  = mk;
    w.fin    = last;
    return w;
  endfunction

  localparam ctrl_t CTRL_NOP = '{alu_a: SRC_ZERO, alu_b: SRC_ZERO, op: ALU_ADD,
                                 dst: DST_NONE, mul_en: 1'b0, mul_a: SRC_ZERO,
                                 mul_k: K_COSH, fin: 1'b0};

  // step program: t0/t1 hold the step lengths on entry, p ends in t0,
  // new position in t3 and new velocity in t5
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      // half next step
      5'd0:  w = ucw(SRC_T1,   SRC_ZERO, ALU_HALF, DST_T1,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // advance nominal foot, end velocity product
      5'd1:  w = ucw(SRC_NF,   SRC_T0,   ALU_ADD,  DST_NF,   1'b1, SRC_T1,   K_EVG,  1'b0);
      // end position target
      5'd2:  w = ucw(SRC_NF,   SRC_T1,   ALU_ADD,  DST_T0,   1'b1, SRC_XI,   K_COSH, 1'b0);
      5'd3:  w = ucw(SRC_MUL,  SRC_ZERO, ALU_ADD,  DST_T2,   1'b1, SRC_VI,   K_TCS,  1'b0);
      5'd4:  w = ucw(SRC_MUL,  SRC_ZERO, ALU_ADD,  DST_T3,   1'b1, SRC_XI,   K_SOVT, 1'b0);
      5'd5:  w = ucw(SRC_MUL,  SRC_ZERO, ALU_ADD,  DST_T4,   1'b1, SRC_VI,   K_COSH, 1'b0);
      5'd6:  w = ucw(SRC_MUL,  SRC_ZERO, ALU_ADD,  DST_T5,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      5'd7:  w = ucw(SRC_MUL,  SRC_ZERO, ALU_ADD,  DST_T1,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // position error
      5'd8:  w = ucw(SRC_T0,   SRC_T3,   ALU_SUB,  DST_T0,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      5'd9:  w = ucw(SRC_T0,   SRC_T4,   ALU_SUB,  DST_T0,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // velocity error
      5'd10: w = ucw(SRC_T2,   SRC_T5,   ALU_SUB,  DST_T2,   1'b1, SRC_T0,   K_PW,   1'b0);
      5'd11: w = ucw(SRC_T2,   SRC_T1,   ALU_SUB,  DST_T2,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // modified foot position
      5'd12: w = ucw(SRC_ZERO, SRC_MUL,  ALU_SUB,  DST_T0,   1'b1, SRC_T2,   K_VW,   1'b0);
      5'd13: w = ucw(SRC_T3,   SRC_T4,   ALU_ADD,  DST_T3,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      5'd14: w = ucw(SRC_T0,   SRC_MUL,  ALU_SUB,  DST_T0,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // propagate over the support period
      5'd15: w = ucw(SRC_T5,   SRC_T1,   ALU_ADD,  DST_T5,   1'b1, SRC_T0,   K_OMC,  1'b0);
      5'd16: w = ucw(SRC_ZERO, SRC_ZERO, ALU_ADD,  DST_NONE, 1'b1, SRC_T0,   K_SOVT, 1'b0);
      5'd17: w = ucw(SRC_T3,   SRC_MUL,  ALU_ADD,  DST_T3,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      5'd18: w = ucw(SRC_T5,   SRC_MUL,  ALU_SUB,  DST_T5,   1'b0, SRC_ZERO, K_COSH, 1'b0);
      // hand over result, commit state
      default: w = ucw(SRC_ZERO, SRC_ZERO, ALU_ADD, DST_NONE, 1'b0, SRC_ZERO, K_COSH, 1'b1);
    endcase
    return w;
  endfunction

endpackage

// ===== design/lfp_mul.sv =====
module lfp_mul #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [32:0]  k,
  output logic signed [W-1:0] res,
  output logic                ov,
  output logic                vld
);

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;
  localparam int PW = W + 32;
  localparam int MW = PW - F;
  localparam logic [PW-1:0] RND = PW'(1) << (F - 1);

  logic [W-1:0]     ua;
  logic [32:0]      uk_full;
  logic [31:0]      uk;
  logic [LO+31:0]   plo_nxt;
  logic [HI+31:0]   phi_nxt;
  logic [LO+31:0]   plo_r;
  logic [HI+31:0]   phi_r;
  logic             neg_r;
  logic             v1_r;
  logic [PW-1:0]    sum;
  logic [MW-1:0]    mag;
  logic             pos_ov;
  logic             neg_ov;
  logic [W-1:0]     res_nxt;
  logic             ov_nxt;
  logic [W-1:0]     res_r;
  logic             ov_r;
  logic             vld_r;

  // stage 1: magnitudes and two partial products
  always_comb begin
    ua      = a[W-1] ? (~a + W'(1)) : a;
    uk_full = k[32] ? (~k + 33'd1) : k;
    uk      = uk_full[31:0];
    plo_nxt = ua[LO-1:0] * uk;
    phi_nxt = ua[W-1:LO] * uk;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
      neg_r <= a[W-1] ^ k[32];
    end
  end

  // stage 2: combine, round half away from zero, saturate
  always_comb begin
    sum    = (PW'(phi_r) << LO) + PW'(plo_r) + RND;
    mag    = sum[PW-1:F];
    pos_ov = |mag[MW-1:W-1];
    neg_ov = (|mag[MW-1:W]) | (mag[W-1] & (|mag[W-2:0]));
    if (neg_r) begin
      ov_nxt  = neg_ov;
      res_nxt = neg_ov ? {1'b1, {(W-1){1'b0}}} : (~mag[W-1:0] + W'(1));
    end else begin
      ov_nxt  = pos_ov;
      res_nxt = pos_ov ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      res_r <= res_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      v1_r  <= en;
      vld_r <= v1_r;
    end
  end

  assign res = res_r;
  assign ov  = ov_r;
  assign vld = vld_r;

endmodule

// ===== design/lfp_seq.sv =====
module lfp_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           out_free,
  output lfp_pkg::ctrl_t ctrl,
  output logic           busy
);

  lfp_pkg::seq_state_t         state_r;
  lfp_pkg::seq_state_t         state_nxt;
  logic [lfp_pkg::PC_W-1:0]    pc_r;
  logic [lfp_pkg::PC_W-1:0]    pc_nxt;
  lfp_pkg::ctrl_t              word;

  // control store read
  assign word = lfp_pkg::ucode(pc_r);

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      lfp_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = lfp_pkg::SEQ_RUN;
          pc_nxt    = '0;
        end
      end
      lfp_pkg::SEQ_RUN: begin
        // last step waits until the result register is free
        if (word.fin) begin
          if (out_free) begin
            state_nxt = lfp_pkg::SEQ_IDLE;
          end
        end else begin
          pc_nxt = pc_r + lfp_pkg::PC_W'(1);
        end
      end
      default: begin
        state_nxt = lfp_pkg::SEQ_IDLE;
      end
    endcase
  end

  // control word to the datapath
  always_comb begin
    ctrl = lfp_pkg::CTRL_NOP;
    busy = 1'b1;
    unique case (state_r)
      lfp_pkg::SEQ_IDLE: begin
        busy = 1'b0;
      end
      lfp_pkg::SEQ_RUN: begin
        ctrl     = word;
        ctrl.fin = word.fin & out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfp_pkg::SEQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// ===== design/lfp_dpath.sv =====
module lfp_dpath #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         step_length,
  input  logic [31:0]         next_step_length,
  input  lfp_pkg::ctrl_t      ctrl,
  input  logic [31:0]         cosh_coef,
  input  logic [31:0]         sinh_over_tc,
  input  logic [31:0]         tc_times_sinh,
  input  logic [31:0]         end_velocity_gain,
  input  logic [31:0]         position_weight_gain,
  input  logic [31:0]         velocity_weight_gain,
  output logic signed [W-1:0] foot_q,
  output logic signed [W-1:0] xi_q,
  output logic signed [W-1:0] vi_q,
  output logic                ov_q
);

  localparam int IW = (W > 32) ? W : 32;

  logic signed [W-1:0] nf_r;
  logic signed [W-1:0] xi_r;
  logic signed [W-1:0] vi_r;
  logic signed [W-1:0] t0_r;
  logic signed [W-1:0] t1_r;
  logic signed [W-1:0] t2_r;
  logic signed [W-1:0] t3_r;
  logic signed [W-1:0] t4_r;
  logic signed [W-1:0] t5_r;
  logic                ov_r;
  logic                ov_nxt;

  logic signed [W-1:0] mul_res;
  logic                mul_ov;
  logic                mul_vld;
  logic signed [W-1:0] mul_a;
  logic signed [32:0]  mul_k;

  logic signed [W-1:0] alu_a;
  logic signed [W-1:0] alu_b;
  logic [W:0]          alu_sum;
  logic [W-1:0]        alu_nxt;
  logic                alu_ov;

  logic [W:0]          len_sat;
  logic [W:0]          nxt_sat;

  // clamp a 32-bit input to the datapath width, flag in the top bit
  function automatic logic [W:0] sat_in(input logic [31:0] x);
    logic [IW-1:0] e;
    logic          o;
    e = IW'($signed(x));
    o = !((&e[IW-1:W-1]) | ~(|e[IW-1:W-1]));
    return o ? {1'b1, e[IW-1], {(W-1){~e[IW-1]}}} : {1'b0, e[W-1:0]};
  endfunction

  // operand selection
  function automatic logic [W-1:0] pick(input lfp_pkg::src_t sel);
    logic [W-1:0] v;
    case (sel)
      lfp_pkg::SRC_NF:  v = nf_r;
      lfp_pkg::SRC_XI:  v = xi_r;
      lfp_pkg::SRC_VI:  v = vi_r;
      lfp_pkg::SRC_T0:  v = t0_r;
      lfp_pkg::SRC_T1:  v = t1_r;
      lfp_pkg::SRC_T2:  v = t2_r;
      lfp_pkg::SRC_T3:  v = t3_r;
      lfp_pkg::SRC_T4:  v = t4_r;
      lfp_pkg::SRC_T5:  v = t5_r;
      lfp_pkg::SRC_MUL: v = mul_res;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign len_sat = sat_in(step_length);
  assign nxt_sat = sat_in(next_step_length);

  // coefficient selection, one minus cosh formed on the fly
  always_comb begin
    mul_a = pick(ctrl.mul_a);
    unique case (ctrl.mul_k)
      lfp_pkg::K_COSH: mul_k = {cosh_coef[31], cosh_coef};
      lfp_pkg::K_SOVT: mul_k = {sinh_over_tc[31], sinh_over_tc};
      lfp_pkg::K_TCS:  mul_k = {tc_times_sinh[31], tc_times_sinh};
      lfp_pkg::K_EVG:  mul_k = {end_velocity_gain[31], end_velocity_gain};
      lfp_pkg::K_PW:   mul_k = {position_weight_gain[31], position_weight_gain};
      lfp_pkg::K_VW:   mul_k = {velocity_weight_gain[31], velocity_weight_gain};
      lfp_pkg::K_OMC:  mul_k = (33'd1 << F) - {cosh_coef[31], cosh_coef};
      default:         mul_k = '0;
    endcase
  end

  lfp_mul #(
    .W (W),
    .F (F)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (ctrl.mul_en),
    .a     (mul_a),
    .k     (mul_k),
    .res   (mul_res),
    .ov    (mul_ov),
    .vld   (mul_vld)
  );

  // saturating add / subtract, halving shift
  always_comb begin
    alu_a   = pick(ctrl.alu_a);
    alu_b   = pick(ctrl.alu_b);
    alu_sum = '0;
    alu_ov  = 1'b0;
    alu_nxt = alu_a;
    case (ctrl.op) inside
      lfp_pkg::ALU_ADD,
      lfp_pkg::ALU_SUB: begin
        if (ctrl.op == lfp_pkg::ALU_ADD) begin
          alu_sum = {alu_a[W-1], alu_a} + {alu_b[W-1], alu_b};
        end else begin
          alu_sum = {alu_a[W-1], alu_a} - {alu_b[W-1], alu_b};
        end
        alu_ov  = alu_sum[W] ^ alu_sum[W-1];
        alu_nxt = alu_ov ? {alu_sum[W], {(W-1){~alu_sum[W]}}} : alu_sum[W-1:0];
      end
      lfp_pkg::ALU_HALF: begin
        alu_nxt = alu_a >>> 1;
      end
      default: begin
        alu_nxt = alu_a;
      end
    endcase
  end

  // sticky overflow for the current step
  always_comb begin
    if (start) begin
      ov_nxt = len_sat[W] | nxt_sat[W];
    end else begin
      ov_nxt = ov_r | ((ctrl.dst != lfp_pkg::DST_NONE) & alu_ov) | (mul_vld & mul_ov);
    end
  end

  always_ff @(posedge clk) begin
    ov_r <= ov_nxt;
  end

  // planner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= '0;
      xi_r <= '0;
      vi_r <= '0;
    end else begin
      if (ctrl.dst == lfp_pkg::DST_NF) begin
        nf_r <= alu_nxt;
      end
      if (ctrl.fin) begin
        xi_r <= t3_r;
        vi_r <= t5_r;
      end
    end
  end

  // scratch registers
  always_ff @(posedge clk) begin
    if (start) begin
      t0_r <= len_sat[W-1:0];
      t1_r <= nxt_sat[W-1:0];
    end else begin
      case (ctrl.dst)
        lfp_pkg::DST_T0: t0_r <= alu_nxt;
        lfp_pkg::DST_T1: t1_r <= alu_nxt;
        lfp_pkg::DST_T2: t2_r <= alu_nxt;
        lfp_pkg::DST_T3: t3_r <= alu_nxt;
        lfp_pkg::DST_T4: t4_r <= alu_nxt;
        lfp_pkg::DST_T5: t5_r <= alu_nxt;
        default: begin
        end
      endcase
    end
  end

  assign foot_q = t0_r;
  assign xi_q   = xi_r;
  assign vi_q   = vi_r;
  assign ov_q   = ov_r;

endmodule

// ===== design/lipm_footstep_planner.sv =====
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tdata: step_length, next_step_length
// out_      out  out_tvalid/out_tready tdata: step_number, foot, com pos, com vel;
//                                       tuser: overflow
// cfg_      in   psel/penable/pready   6 coefficient registers at 4*i
//
// A step runs as 20 microcode steps from acceptance to the next possible
// acceptance, set by the single shared coefficient multiplier (two-stage
// pipeline, nine products a step) and the one-write alu.
// The result appears the cycle after the last step; the next step is accepted
// while it waits. If it is still not taken, the last step holds.
// rst_n (synchronous) clears the planner state and counter and loads the
// coefficient defaults.
module lipm_footstep_planner #(
  parameter int DATA_WIDTH     = 32,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // step_length [31:0], next_step_length [63:32]
  input  logic [lfp_pkg::IN_DW-1:0]    in_tdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // step_number [15:0], modified_foot_position [47:16],
  // start_com_position [79:48], start_com_velocity [111:80]
  output logic [lfp_pkg::OUT_DW-1:0]   out_tdata,
  // overflow [0]
  output logic [0:0]                   out_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lfp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [lfp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lfp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int W  = DATA_WIDTH;
  localparam int OW = (W > 32) ? W : 32;

  logic [31:0] cosh_r;
  logic [31:0] sovt_r;
  logic [31:0] tcs_r;
  logic [31:0] evg_r;
  logic [31:0] pw_r;
  logic [31:0] vw_r;

  logic                      cfg_wr;
  logic [2:0]                cfg_idx;
  logic                      start;
  logic                      busy;
  logic                      out_free;
  lfp_pkg::ctrl_t            ctrl;
  logic signed [W-1:0]       foot_q;
  logic signed [W-1:0]       xi_q;
  logic signed [W-1:0]       vi_q;
  logic                      ov_q;

  logic [lfp_pkg::CNT_W-1:0] cnt_r;
  logic [lfp_pkg::CNT_W-1:0] cnt_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [lfp_pkg::OUT_DW-1:0] out_data_r;
  logic                      out_ov_r;
  logic [32:0]               foot_o;
  logic [32:0]               xi_o;
  logic [32:0]               vi_o;

  // clamp to the 32-bit result field, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [W-1:0] v);
    logic [OW-1:0] e;
    logic          o;
    e = OW'(v);
    o = !((&e[OW-1:31]) | ~(|e[OW-1:31]));
    return o ? {1'b1, e[OW-1], {31{~e[OW-1]}}} : {1'b0, e[31:0]};
  endfunction

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cosh_r <= lfp_pkg::COSH_RST;
      sovt_r <= lfp_pkg::SOVT_RST;
      tcs_r  <= lfp_pkg::TCS_RST;
      evg_r  <= lfp_pkg::EVG_RST;
      pw_r   <= lfp_pkg::PW_RST;
      vw_r   <= lfp_pkg::VW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lfp_pkg::REG_COSH: cosh_r <= cfg_pwdata;
        lfp_pkg::REG_SOVT: sovt_r <= cfg_pwdata;
        lfp_pkg::REG_TCS:  tcs_r  <= cfg_pwdata;
        lfp_pkg::REG_EVG:  evg_r  <= cfg_pwdata;
        lfp_pkg::REG_PW:   pw_r   <= cfg_pwdata;
        lfp_pkg::REG_VW:   vw_r   <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      lfp_pkg::REG_COSH: cfg_prdata = cosh_r;
      lfp_pkg::REG_SOVT: cfg_prdata = sovt_r;
      lfp_pkg::REG_TCS:  cfg_prdata = tcs_r;
      lfp_pkg::REG_EVG:  cfg_prdata = evg_r;
      lfp_pkg::REG_PW:   cfg_prdata = pw_r;
      lfp_pkg::REG_VW:   cfg_prdata = vw_r;
      default:           cfg_prdata = '0;
    endcase
  end

  // input request
  assign in_tready = ~busy;
  assign start     = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  lfp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  lfp_dpath #(
    .W (W),
    .F (COEF_FRAC_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .step_length          (in_tdata[31:0]),
    .next_step_length     (in_tdata[63:32]),
    .ctrl                 (ctrl),
    .cosh_coef            (cosh_r),
    .sinh_over_tc         (sovt_r),
    .tc_times_sinh        (tcs_r),
    .end_velocity_gain    (evg_r),
    .position_weight_gain (pw_r),
    .velocity_weight_gain (vw_r),
    .foot_q               (foot_q),
    .xi_q                 (xi_q),
    .vi_q                 (vi_q),
    .ov_q                 (ov_q)
  );

  // result fields
  assign foot_o  = sat32(foot_q);
  assign xi_o    = sat32(xi_q);
  assign vi_o    = sat32(vi_q);
  assign cnt_nxt = cnt_r + lfp_pkg::CNT_W'(1);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // output request register and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.fin) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      out_data_r <= {vi_o[31:0], xi_o[31:0], foot_o[31:0], cnt_nxt};
      out_ov_r   <= ov_q | foot_o[32] | xi_o[32] | vi_o[32];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ov_r;

  // busy right after taking a request
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("input taken while a step is in progress");

  // a step only completes into a free result register
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fin |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // completion presents a result and advances the counter by one
  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.fin |=> (out_tvalid && (cnt_r == $past(cnt_r) + 16'd1)))
    else $error("step completion out of step with counter");

  // a result only appears after a completed step
  a_rose_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(ctrl.fin))
    else $error("result without a completed step");

endmodule

// ===== sim/tb_lipm_footstep_planner.sv =====
module tb_lipm_footstep_planner;

  localparam int DW           = 32;
  localparam int FRAC         = 24;
  localparam int STEP_LAT     = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  // addresses past the register map
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // one planned footstep as it should leave the block
  typedef struct {
    logic [15:0] step_no;
    logic [31:0] foot;
    logic [31:0] com_pos;
    logic [31:0] com_vel;
    logic        ovf;
  } step_plan_t;

  // footstep predictor and store of planned steps
  class footstep_scoreboard;
    longint   k_cosh, k_sovt, k_tcs, k_evg, k_pw, k_vw;
    longint   nom_foot, com_pos, com_vel;
    bit [15:0] step_cnt;
    bit       sat_hit;
    int       errors;
    step_plan_t planned_steps[$];

    function new();
      k_cosh   = $signed(lfp_pkg::COSH_RST);
      k_sovt   = $signed(lfp_pkg::SOVT_RST);
      k_tcs    = $signed(lfp_pkg::TCS_RST);
      k_evg    = $signed(lfp_pkg::EVG_RST);
      k_pw     = $signed(lfp_pkg::PW_RST);
      k_vw     = $signed(lfp_pkg::VW_RST);
      nom_foot = 0;
      com_pos  = 0;
      com_vel  = 0;
      step_cnt = '0;
      errors   = 0;
    endfunction

    function void load_coef(logic [2:0] idx, logic [31:0] v);
      case (lfp_pkg::reg_idx_t'(idx))
        lfp_pkg::REG_COSH: k_cosh = $signed(v);
        lfp_pkg::REG_SOVT: k_sovt = $signed(v);
        lfp_pkg::REG_TCS:  k_tcs  = $signed(v);
        lfp_pkg::REG_EVG:  k_evg  = $signed(v);
        lfp_pkg::REG_PW:   k_pw   = $signed(v);
        lfp_pkg::REG_VW:   k_vw   = $signed(v);
        default: ;
      endcase
    endfunction

    function void mismatch(string what, longint e, longint a);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, e, a);
    endfunction

    function longint clamp_w(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        sat_hit = 1'b1;
        return hi;
      end
      if (v < lo) begin
        sat_hit = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function longint clamp(longint v);
      return clamp_w(v, DW);
    endfunction

    // value times coefficient, rounded half away from zero, saturated
    function longint scale(longint x, longint k);
      bit neg;
      longint unsigned ux, uk, hp, lp, half, r;
      neg  = (x < 0) != (k < 0);
      ux   = (x < 0) ? -x : x;
      uk   = (k < 0) ? -k : k;
      hp   = (ux >> 32) * uk;
      lp   = (ux & 64'hffff_ffff) * uk;
      half = 64'd1 << (FRAC - 1);
      if ((hp >> (30 + FRAC)) != 0)
        r = 64'd1 << 62;
      else
        r = (hp << (32 - FRAC)) + ((lp + half) >> FRAC);
      if (r > (64'd1 << 62))
        r = 64'd1 << 62;
      return clamp(neg ? -longint'(r) : longint'(r));
    endfunction

    // accepted request: plan the step and queue its result
    function void take_step(logic [31:0] len_in, logic [31:0] nxt_in);
      longint len, nxt, xi, vi, xb, vb, xd, e1, e2, p, xf, vf, omc;
      step_plan_t s;
      sat_hit  = 1'b0;
      len      = clamp($signed(len_in));
      nxt      = clamp($signed(nxt_in));
      omc      = (longint'(1) <<< FRAC) - k_cosh;
      step_cnt = step_cnt + 16'd1;
      nom_foot = clamp(nom_foot + len);
      xi       = com_pos;
      vi       = com_vel;
      // end target of the walking primitive
      xb = nxt >>> 1;
      vb = scale(xb, k_evg);
      xd = clamp(nom_foot + xb);
      // weighted errors and modified foot
      e1 = clamp(xd - scale(xi, k_cosh));
      e1 = clamp(e1 - scale(vi, k_tcs));
      e2 = clamp(vb - scale(xi, k_sovt));
      e2 = clamp(e2 - scale(vi, k_cosh));
      p  = clamp(0 - scale(e1, k_pw));
      p  = clamp(p - scale(e2, k_vw));
      // propagate over one support period
      xf = clamp(scale(xi, k_cosh) + scale(vi, k_tcs));
      xf = clamp(xf + scale(p, omc));
      vf = clamp(scale(xi, k_sovt) + scale(vi, k_cosh));
      vf = clamp(vf - scale(p, k_sovt));
      com_pos = xf;
      com_vel = vf;
      s.step_no = step_cnt;
      s.foot    = clamp_w(p, 32);
      s.com_pos = clamp_w(xi, 32);
      s.com_vel = clamp_w(vi, 32);
      s.ovf     = sat_hit;
      planned_steps.insert(planned_steps.size(), s);
    endfunction

    function void check_step(logic [lfp_pkg::OUT_DW-1:0] d, logic [0:0] u);
      step_plan_t s;
      if (planned_steps.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, got %0h/%0h",
                 $time, d, u);
        return;
      end
      s = planned_steps.pop_front();
      if (d[15:0] !== s.step_no)   mismatch("step_number", s.step_no, d[15:0]);
      if (d[47:16] !== s.foot)     mismatch("modified_foot_position", s.foot, d[47:16]);
      if (d[79:48] !== s.com_pos)  mismatch("start_com_position", s.com_pos, d[79:48]);
      if (d[111:80] !== s.com_vel) mismatch("start_com_velocity", s.com_vel, d[111:80]);
      if (u[0] !== s.ovf)          mismatch("overflow", s.ovf, u[0]);
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic [lfp_pkg::IN_DW-1:0]  in_tdata = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [lfp_pkg::OUT_DW-1:0] out_tdata;
  logic [0:0]                 out_tuser;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [lfp_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [lfp_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [lfp_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_used = 1'b0;
  int   hold_left = 0;
  int   cycles = 0;
  int   sent = 0;

  footstep_scoreboard sb = new();

  lipm_footstep_planner #(
    .DATA_WIDTH    (DW),
    .COEF_FRAC_BITS(FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lipm_footstep_planner verification failed");
      $finish;
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 36);
    end
  end

  // monitor both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_step(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        sb.take_step(in_tdata[31:0], in_tdata[63:32]);
    end
  end

  // realistic stride, about -0.1 m to 0.7 m
  function automatic logic [31:0] walk_length();
    return 32'($urandom_range(52428)) - 32'd6554;
  endfunction

  function automatic logic [31:0] any_length();
    int r;
    r = $urandom_range(99);
    case ($urandom_range(4))
      0: any_length = Q_MAX;
      1: any_length = Q_MIN;
      2: any_length = '0;
      3: any_length = '1;
      default: any_length = 32'd1;
    endcase
    if (r >= 8)
      any_length = (r < 20) ? $urandom() : walk_length();
  endfunction

  task automatic send_step(input logic [31:0] len, input logic [31:0] nxt);
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {nxt, len};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // stop offering and wait for every planned step to come back
  task automatic drain_steps();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.planned_steps.size() != 0) @(posedge clk);
    repeat (STEP_LAT) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.load_coef(idx, v);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [2:0] idx, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== v)
      sb.mismatch("register read", v, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(input logic [31:0] c, input logic [31:0] sovt,
                            input logic [31:0] tcs, input logic [31:0] evg,
                            input logic [31:0] pw, input logic [31:0] vw);
    apb_write(lfp_pkg::REG_COSH, c);
    apb_write(lfp_pkg::REG_SOVT, sovt);
    apb_write(lfp_pkg::REG_TCS, tcs);
    apb_write(lfp_pkg::REG_EVG, evg);
    apb_write(lfp_pkg::REG_PW, pw);
    apb_write(lfp_pkg::REG_VW, vw);
    apb_read_check(lfp_pkg::REG_COSH, c);
    apb_read_check(lfp_pkg::REG_SOVT, sovt);
    apb_read_check(lfp_pkg::REG_TCS, tcs);
    apb_read_check(lfp_pkg::REG_EVG, evg);
    apb_read_check(lfp_pkg::REG_PW, pw);
    apb_read_check(lfp_pkg::REG_VW, vw);
  endtask

  task automatic walk_random(input int n);
    for (int i = 0; i < n; i++)
      send_step(any_length(), any_length());
  endtask

  // small random change around a default coefficient
  function automatic logic [31:0] nudge(input logic [31:0] v);
    return v + 32'($urandom_range(v >> 2)) - (v >> 3);
  endfunction

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first and last registers hold their defaults after reset
    apb_read_check(lfp_pkg::REG_COSH, lfp_pkg::COSH_RST);
    apb_read_check(lfp_pkg::REG_VW, lfp_pkg::VW_RST);

    // directed: field extremes, floor halving, saturation
    send_step('0, '0);
    send_step(32'd19661, 32'd19661);
    send_step(Q_ONE, Q_ONE);
    send_step(32'd1, 32'd1);
    send_step('1, '1);
    send_step('0, 32'hffff_fffd);
    send_step(Q_MAX, Q_MAX);
    send_step(Q_MAX, Q_MAX);
    send_step(Q_MIN, Q_MIN);
    send_step(Q_MIN, Q_MAX);
    send_step(Q_MAX, Q_MIN);
    send_step(32'h5555_5555, 32'haaaa_aaaa);
    send_step(32'haaaa_aaaa, 32'h5555_5555);
    send_step(-Q_ONE, -Q_ONE);
    for (int i = 0; i < 8; i++)
      send_step(32'd19661, 32'd19661);

    // defaults, random walk with a long result hold-off and a full pause
    for (int i = 0; i < 250; i++) begin
      if (i == 100)
        hold_req <= 1'b1;
      if (i == 180)
        drain_steps();
      send_step(any_length(), any_length());
    end
    drain_steps();

    // long steady walk with no idling on either side
    steady <= 1'b1;
    n = 150;
    for (int i = 0; i < n; i++)
      send_step(walk_length(), walk_length());
    steady <= 1'b0;
    drain_steps();

    // coefficients near the defaults
    load_coefs(nudge(lfp_pkg::COSH_RST), nudge(lfp_pkg::SOVT_RST), nudge(lfp_pkg::TCS_RST),
               nudge(lfp_pkg::EVG_RST), nudge(lfp_pkg::PW_RST), nudge(lfp_pkg::VW_RST));
    walk_random(200);
    drain_steps();

    // extreme coefficient settings
    load_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    walk_random(150);
    drain_steps();
    load_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    walk_random(150);
    drain_steps();
    load_coefs('0, '0, '0, '0, '0, '0);
    walk_random(100);
    drain_steps();
    load_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    walk_random(150);
    drain_steps();

    // back to defaults, writes past the map must change nothing
    load_coefs(lfp_pkg::COSH_RST, lfp_pkg::SOVT_RST, lfp_pkg::TCS_RST,
               lfp_pkg::EVG_RST, lfp_pkg::PW_RST, lfp_pkg::VW_RST);
    apb_write(REG_SPARE_LO, $urandom());
    apb_write(REG_SPARE_HI, $urandom());
    apb_read_check(lfp_pkg::REG_COSH, lfp_pkg::COSH_RST);
    apb_read_check(lfp_pkg::REG_VW, lfp_pkg::VW_RST);
    walk_random(100);

    drain_steps();
    if (sb.errors == 0)
      $display("lipm_footstep_planner verification clean");
    else
      $display("lipm_footstep_planner verification failed");
    $finish;
  end

endmodule
